// File: hw/rtl/vabe_pkg.sv
// Shared types and constants of the VM ALU/branch execute unit.
package vabe_pkg;

  localparam int unsigned DW     = 32;
  localparam int unsigned OPC_W  = 5;
  localparam int unsigned CNT_W  = $clog2(DW);
  localparam int unsigned SHAMT_W = $clog2(DW);

  localparam int unsigned FLAG_Z = 0;
  localparam int unsigned FLAG_N = 1;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 5'd0,
    OP_MOV  = 5'd1,
    OP_SUB  = 5'd2,
    OP_MUL  = 5'd3,
    OP_DIV  = 5'd4,
    OP_MOD  = 5'd5,
    OP_CMP  = 5'd6,
    OP_SWAP = 5'd7,
    OP_JMP  = 5'd8,
    OP_JE   = 5'd9,
    OP_JG   = 5'd10,
    OP_JL   = 5'd11,
    OP_JZ   = 5'd12,
    OP_JP   = 5'd13,
    OP_JN   = 5'd14,
    OP_JNZ  = 5'd15,
    OP_JNP  = 5'd16,
    OP_JNN  = 5'd17,
    OP_AND  = 5'd18,
    OP_OR   = 5'd19,
    OP_NOT  = 5'd20,
    OP_XOR  = 5'd21,
    OP_SHL  = 5'd22,
    OP_SHR  = 5'd23,
    OP_STOP = 5'd24
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  // request to the iterative multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

// File: hw/rtl/vabe_in_if.sv
// Instruction input channel: valid/ready plus opcode and operand values.
interface vabe_in_if;
  logic                             valid;
  logic                             ready;
  logic [vabe_pkg::OPC_W-1:0]       opcode;
  logic signed [vabe_pkg::DW-1:0]   operand_a;
  logic signed [vabe_pkg::DW-1:0]   operand_b;
  logic signed [vabe_pkg::DW-1:0]   accumulator;

  modport source (output valid, opcode, operand_a, operand_b, accumulator, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, accumulator, output ready);
endinterface

// File: hw/rtl/vabe_out_if.sv
// Result output channel: valid/ready plus write-back, branch, error and flag fields.
interface vabe_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [vabe_pkg::DW-1:0]   result_a;
  logic                             write_a;
  logic signed [vabe_pkg::DW-1:0]   result_b;
  logic                             write_b;
  logic                             branch_taken;
  logic signed [vabe_pkg::DW-1:0]   branch_target;
  logic                             divide_by_zero;
  logic                             halt;
  logic                             zero_flag;
  logic                             negative_flag;

  modport source (output valid, result_a, write_a, result_b, write_b, branch_taken,
                  branch_target, divide_by_zero, halt, zero_flag, negative_flag,
                  input ready);
  modport sink   (input valid, result_a, write_a, result_b, write_b, branch_taken,
                  branch_target, divide_by_zero, halt, zero_flag, negative_flag,
                  output ready);
endinterface

// File: hw/rtl/vm_alu_branch_execute_core.sv
// Execute unit of a small VM: ALU ops, flags, jumps, with an iterative mul/div unit.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-----------------------------------------------
//   in_i     | in  | valid / ready    | opcode, operand_a, operand_b, accumulator
//   out_o    | out | valid / ready    | result_a/b, write_a/b, branch_taken/target,
//            |     |                  | divide_by_zero, halt, zero_flag, negative_flag
//
// Logic, move, compare, shift, jump, ADD/SUB, STOP and DIV/MOD with a zero divisor: latch, then finish.
// MUL, and DIV/MOD with a nonzero divisor: latch, then the 32 steps of the shared add/subtract
//   in vabe_muldiv, then done and finish.
// in_i.ready is high only while idle; a result waiting in the output register does
//   not block the next input beat, only the finish of that beat.
// Reset clears the flags, the sequencer and the output valid.
module vm_alu_branch_execute_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  vabe_in_if.sink    in_i,
  vabe_out_if.source out_o
);

  localparam int unsigned DW = vabe_pkg::DW;

  function automatic logic [1:0] flags_of(input logic [DW-1:0] v);
    logic [1:0] f;
    f = '0;
    f[vabe_pkg::FLAG_Z] = (v == '0);
    f[vabe_pkg::FLAG_N] = v[DW-1];
    return f;
  endfunction

  vabe_pkg::state_e   state_q, state_d;
  vabe_pkg::op_e      op_q;
  logic [DW-1:0]      a_q, b_q, cmp_q;
  logic [1:0]         flags_q;

  logic               accept, load, in_md, in_div;
  vabe_pkg::md_req_t  md_req;
  vabe_pkg::md_rsp_t  md_rsp;
  logic [DW-1:0]      md_pr, md_qt;

  // finish-stage results
  logic [DW-1:0]      ra, rb, fval, line, tline, tgt, addsub, q_s, r_s, shl, shr;
  logic               wa, wb, taken, dbz, hlt, setf, sub, big, use_b_line;
  logic [1:0]         flags_d;

  // output register
  logic               out_valid_q;
  logic [DW-1:0]      res_a_q, res_b_q, tgt_q;
  logic               wa_q, wb_q, taken_q, dbz_q, hlt_q;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == vabe_pkg::ST_IDLE);
  assign in_div     = (in_i.opcode == vabe_pkg::OP_DIV) || (in_i.opcode == vabe_pkg::OP_MOD);
  assign in_md      = (in_i.opcode == vabe_pkg::OP_MUL) || (in_div && (in_i.operand_b != '0));

  assign md_req.start  = accept && in_md;
  assign md_req.is_div = in_div;

  vabe_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (in_i.operand_a),
    .b_i    (in_i.operand_b),
    .rsp_o  (md_rsp),
    .pr_o   (md_pr),
    .qt_o   (md_qt)
  );

  assign load = (state_q == vabe_pkg::ST_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      vabe_pkg::ST_IDLE: if (accept) begin
        state_d = in_md ? vabe_pkg::ST_CALC : vabe_pkg::ST_FIN;
      end
      vabe_pkg::ST_CALC: if (md_rsp.done && !md_rsp.busy) begin
        state_d = vabe_pkg::ST_FIN;
      end
      vabe_pkg::ST_FIN: if (load) begin
        state_d = vabe_pkg::ST_IDLE;
      end
      default: state_d = vabe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vabe_pkg::ST_IDLE;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        flags_q     <= flags_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= vabe_pkg::op_e'(in_i.opcode);
      a_q   <= in_i.operand_a;
      b_q   <= in_i.operand_b;
      cmp_q <= in_i.accumulator;
    end
  end

  // shared add/sub for ADD, SUB and CMP
  assign sub    = (op_q != vabe_pkg::OP_ADD);
  assign addsub = a_q + (sub ? ~b_q : b_q) + {{(DW-1){1'b0}}, sub};

  // sign fix of the magnitude divide: quotient toward zero, remainder follows dividend
  assign q_s = (a_q[DW-1] ^ b_q[DW-1]) ? (~md_qt + 1'b1) : md_qt;
  assign r_s = a_q[DW-1] ? (~md_pr + 1'b1) : md_pr;

  // negative or out-of-range shift amounts
  assign big = (b_q[DW-1:vabe_pkg::SHAMT_W] != '0);
  assign shl = big ? '0 : (a_q << b_q[vabe_pkg::SHAMT_W-1:0]);
  assign shr = big ? {DW{a_q[DW-1]}}
                   : DW'($signed(a_q) >>> b_q[vabe_pkg::SHAMT_W-1:0]);

  // target = (line - 1) * 3
  assign use_b_line = (op_q == vabe_pkg::OP_JE) || (op_q == vabe_pkg::OP_JG) ||
                      (op_q == vabe_pkg::OP_JL);
  assign line  = use_b_line ? b_q : a_q;
  assign tline = line - 1'b1;
  assign tgt   = tline + {tline[DW-2:0], 1'b0};

  always_comb begin
    ra    = '0;
    rb    = '0;
    wa    = 1'b0;
    wb    = 1'b0;
    taken = 1'b0;
    dbz   = 1'b0;
    hlt   = 1'b0;
    setf  = 1'b0;
    fval  = '0;
    case (op_q)
      vabe_pkg::OP_ADD,
      vabe_pkg::OP_SUB: begin
        ra = addsub; wa = 1'b1; setf = 1'b1; fval = addsub;
      end
      vabe_pkg::OP_MOV: begin
        ra = b_q; wa = 1'b1;
      end
      vabe_pkg::OP_MUL: begin
        ra = md_pr; wa = 1'b1; setf = 1'b1; fval = md_pr;
      end
      vabe_pkg::OP_DIV: begin
        if (b_q == '0) begin
          dbz = 1'b1;
        end else begin
          ra = q_s; wa = 1'b1; setf = 1'b1; fval = q_s;
        end
      end
      vabe_pkg::OP_MOD: begin
        if (b_q == '0) begin
          dbz = 1'b1;
        end else begin
          ra = r_s; wa = 1'b1; setf = 1'b1; fval = q_s;
        end
      end
      vabe_pkg::OP_CMP: begin
        setf = 1'b1; fval = addsub;
      end
      vabe_pkg::OP_SWAP: begin
        ra = b_q; rb = a_q; wa = 1'b1; wb = 1'b1;
      end
      vabe_pkg::OP_JMP: taken = 1'b1;
      vabe_pkg::OP_JE:  taken = (a_q == cmp_q);
      vabe_pkg::OP_JG:  taken = ($signed(cmp_q) < $signed(a_q));
      vabe_pkg::OP_JL:  taken = ($signed(a_q) < $signed(cmp_q));
      vabe_pkg::OP_JZ:  taken = flags_q[vabe_pkg::FLAG_Z];
      vabe_pkg::OP_JP:  taken = (flags_q == '0);
      vabe_pkg::OP_JN:  taken = flags_q[vabe_pkg::FLAG_N];
      vabe_pkg::OP_JNZ: taken = !flags_q[vabe_pkg::FLAG_Z];
      vabe_pkg::OP_JNP: taken = (flags_q != '0);
      vabe_pkg::OP_JNN: taken = !flags_q[vabe_pkg::FLAG_N];
      vabe_pkg::OP_AND: begin
        ra = a_q & b_q; wa = 1'b1; setf = 1'b1; fval = a_q & b_q;
      end
      vabe_pkg::OP_OR: begin
        ra = a_q | b_q; wa = 1'b1; setf = 1'b1; fval = a_q | b_q;
      end
      vabe_pkg::OP_NOT: begin
        ra = ~a_q; wa = 1'b1; setf = 1'b1; fval = ~a_q;
      end
      vabe_pkg::OP_XOR: begin
        ra = a_q ^ b_q; wa = 1'b1; setf = 1'b1; fval = a_q ^ b_q;
      end
      vabe_pkg::OP_SHL: begin
        ra = shl; wa = 1'b1; setf = 1'b1; fval = shl;
      end
      vabe_pkg::OP_SHR: begin
        ra = shr; wa = 1'b1; setf = 1'b1; fval = shr;
      end
      vabe_pkg::OP_STOP: hlt = 1'b1;
      default: ;
    endcase
    flags_d = setf ? flags_of(fval) : flags_q;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_a_q <= ra;
      res_b_q <= rb;
      wa_q    <= wa;
      wb_q    <= wb;
      taken_q <= taken;
      tgt_q   <= taken ? tgt : '0;
      dbz_q   <= dbz;
      hlt_q   <= hlt;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_a       = res_a_q;
  assign out_o.write_a        = wa_q;
  assign out_o.result_b       = res_b_q;
  assign out_o.write_b        = wb_q;
  assign out_o.branch_taken   = taken_q;
  assign out_o.branch_target  = tgt_q;
  assign out_o.divide_by_zero = dbz_q;
  assign out_o.halt           = hlt_q;
  assign out_o.zero_flag      = flags_q[vabe_pkg::FLAG_Z];
  assign out_o.negative_flag  = flags_q[vabe_pkg::FLAG_N];

endmodule

// File: hw/rtl/vabe_muldiv.sv
// Iterative multiply / unsigned divide unit built around one shared add/subtract.
module vabe_muldiv (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vabe_pkg::md_req_t        req_i,
  input  logic [vabe_pkg::DW-1:0]  a_i,
  input  logic [vabe_pkg::DW-1:0]  b_i,
  output vabe_pkg::md_rsp_t        rsp_o,
  output logic [vabe_pkg::DW-1:0]  pr_o,   // product, or remainder magnitude
  output logic [vabe_pkg::DW-1:0]  qt_o    // quotient magnitude
);

  logic                          run_q, div_q, done_q;
  logic [vabe_pkg::CNT_W-1:0]    cnt_q;
  logic [vabe_pkg::DW-1:0]       acc_q, sh_q, dv_q;
  logic [vabe_pkg::DW:0]         add_x, add_y, add_s;
  logic [vabe_pkg::DW-1:0]       mag_a, mag_b;

  assign mag_a = a_i[vabe_pkg::DW-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[vabe_pkg::DW-1] ? (~b_i + 1'b1) : b_i;

  // divide: trial subtract of the shifted partial remainder
  // multiply: add the multiplicand when the current multiplier bit is set
  always_comb begin
    if (div_q) begin
      add_x = {acc_q, sh_q[vabe_pkg::DW-1]};
      add_y = {1'b0, dv_q};
      add_s = add_x - add_y;
    end else begin
      add_x = {1'b0, acc_q};
      add_y = {1'b0, (sh_q[0] ? dv_q : '0)};
      add_s = add_x + add_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (req_i.start) begin
        run_q <= 1'b1;
        div_q <= req_i.is_div;
        cnt_q <= vabe_pkg::CNT_W'(vabe_pkg::DW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      sh_q  <= req_i.is_div ? mag_a : a_i;
      dv_q  <= req_i.is_div ? mag_b : b_i;
    end else if (run_q) begin
      if (div_q) begin
        if (!add_s[vabe_pkg::DW]) begin
          acc_q <= add_s[vabe_pkg::DW-1:0];
          sh_q  <= {sh_q[vabe_pkg::DW-2:0], 1'b1};
        end else begin
          acc_q <= add_x[vabe_pkg::DW-1:0];
          sh_q  <= {sh_q[vabe_pkg::DW-2:0], 1'b0};
        end
      end else begin
        acc_q <= add_s[vabe_pkg::DW-1:0];
        sh_q  <= {1'b0, sh_q[vabe_pkg::DW-1:1]};
        dv_q  <= {dv_q[vabe_pkg::DW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign pr_o       = acc_q;
  assign qt_o       = sh_q;

endmodule

// File: hw/rtl/vabe_checker.sv
// Port-level checks on the execute unit's result beats, bound to the top level.
module vabe_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [vabe_pkg::DW-1:0] result_a_i,
  input logic                    write_a_i,
  input logic                    write_b_i,
  input logic                    branch_taken_i,
  input logic [vabe_pkg::DW-1:0] branch_target_i,
  input logic                    divide_by_zero_i,
  input logic                    halt_i,
  input logic                    zero_flag_i,
  input logic                    negative_flag_i
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_a_i))
    else $error("result beat dropped or changed under stall");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_flag_i |-> !negative_flag_i)
    else $error("zero and negative flags both set");

  a_dbz_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && divide_by_zero_i |-> !write_a_i && !write_b_i && !branch_taken_i)
    else $error("divide by zero beat writes back");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_i |-> !write_a_i && !branch_taken_i && !divide_by_zero_i)
    else $error("halt beat carries other effects");

  a_tgt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !branch_taken_i |-> branch_target_i == '0)
    else $error("branch target set on a not-taken beat");

endmodule

bind vm_alu_branch_execute_core vabe_checker u_vabe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .result_a_i       (out_o.result_a),
  .write_a_i        (out_o.write_a),
  .write_b_i        (out_o.write_b),
  .branch_taken_i   (out_o.branch_taken),
  .branch_target_i  (out_o.branch_target),
  .divide_by_zero_i (out_o.divide_by_zero),
  .halt_i           (out_o.halt),
  .zero_flag_i      (out_o.zero_flag),
  .negative_flag_i  (out_o.negative_flag)
);

// File: tb/tb.sv
// Self-checking testbench of the VM execute core: predicts each result beat and paces both channels.
module tb;

  localparam int unsigned DW = vabe_pkg::DW;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic [DW-1:0] result_a;
    logic          write_a;
    logic [DW-1:0] result_b;
    logic          write_b;
    logic          branch_taken;
    logic [DW-1:0] branch_target;
    logic          divide_by_zero;
    logic          halt;
    logic          zero_flag;
    logic          negative_flag;
  } exec_res_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 360;

  // Expected execute results, with the unit's condition flags tracked alongside.
  class exec_scoreboard;
    exec_res_t   pending[$];
    logic [1:0]  flags = '0;
    int unsigned mismatches = 0;
    int unsigned checked = 0;

    function string fmt(exec_res_t r);
      return $sformatf("a=%h wa=%b b=%h wb=%b tk=%b tg=%h dz=%b h=%b z=%b n=%b",
                       r.result_a, r.write_a, r.result_b, r.write_b, r.branch_taken,
                       r.branch_target, r.divide_by_zero, r.halt, r.zero_flag,
                       r.negative_flag);
    endfunction

    function void note_input(vabe_pkg::op_e op, word_t a, word_t b, word_t acc);
      exec_res_t     r;
      logic [DW-1:0] ma, mb, q, rem;
      word_t         fval, line, sra;
      logic          set_f, big;
      r = '0;
      set_f = 1'b0;
      fval = '0;
      line = a;
      big = b[DW-1] || ($unsigned(b) >= DW);
      case (op)
        vabe_pkg::OP_ADD: begin r.result_a = a + b; r.write_a = 1'b1; end
        vabe_pkg::OP_MOV: begin r.result_a = b; r.write_a = 1'b1; end
        vabe_pkg::OP_SUB: begin r.result_a = a - b; r.write_a = 1'b1; end
        vabe_pkg::OP_MUL: begin r.result_a = a * b; r.write_a = 1'b1; end
        vabe_pkg::OP_DIV, vabe_pkg::OP_MOD: begin
          if (b == 0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            // unsigned magnitudes keep most-negative / -1 well defined
            ma = a[DW-1] ? (~a + 1'b1) : a;
            mb = b[DW-1] ? (~b + 1'b1) : b;
            q = ma / mb;
            rem = ma % mb;
            if (a[DW-1] ^ b[DW-1]) q = ~q + 1'b1;
            if (a[DW-1]) rem = ~rem + 1'b1;
            r.result_a = (op == vabe_pkg::OP_DIV) ? q : rem;
            r.write_a = 1'b1;
            set_f = 1'b1;
            fval = q;
          end
        end
        vabe_pkg::OP_CMP: begin set_f = 1'b1; fval = a - b; end
        vabe_pkg::OP_SWAP: begin
          r.result_a = b; r.result_b = a;
          r.write_a = 1'b1; r.write_b = 1'b1;
        end
        vabe_pkg::OP_JMP: r.branch_taken = 1'b1;
        vabe_pkg::OP_JE: begin r.branch_taken = (a == acc); line = b; end
        vabe_pkg::OP_JG: begin r.branch_taken = (a > acc); line = b; end
        vabe_pkg::OP_JL: begin r.branch_taken = (a < acc); line = b; end
        vabe_pkg::OP_JZ:  r.branch_taken = flags[vabe_pkg::FLAG_Z];
        vabe_pkg::OP_JP:  r.branch_taken = (flags == 2'b00);
        vabe_pkg::OP_JN:  r.branch_taken = flags[vabe_pkg::FLAG_N];
        vabe_pkg::OP_JNZ: r.branch_taken = !flags[vabe_pkg::FLAG_Z];
        vabe_pkg::OP_JNP: r.branch_taken = (flags != 2'b00);
        vabe_pkg::OP_JNN: r.branch_taken = !flags[vabe_pkg::FLAG_N];
        vabe_pkg::OP_AND: begin r.result_a = a & b; r.write_a = 1'b1; end
        vabe_pkg::OP_OR:  begin r.result_a = a | b; r.write_a = 1'b1; end
        vabe_pkg::OP_NOT: begin r.result_a = ~a; r.write_a = 1'b1; end
        vabe_pkg::OP_XOR: begin r.result_a = a ^ b; r.write_a = 1'b1; end
        vabe_pkg::OP_SHL: begin
          r.result_a = big ? '0 : (a << b[vabe_pkg::SHAMT_W-1:0]);
          r.write_a = 1'b1;
        end
        vabe_pkg::OP_SHR: begin
          // shift in a signed variable so the sign fill survives the select below
          sra = a >>> b[vabe_pkg::SHAMT_W-1:0];
          r.result_a = big ? {DW{a[DW-1]}} : sra;
          r.write_a = 1'b1;
        end
        vabe_pkg::OP_STOP: r.halt = 1'b1;
        default: ;
      endcase
      if (r.branch_taken) r.branch_target = (line - 32'sd1) * 32'sd3;
      if (r.write_a && op != vabe_pkg::OP_MOV && op != vabe_pkg::OP_MOD &&
          op != vabe_pkg::OP_SWAP) begin
        set_f = 1'b1;
        fval = r.result_a;
      end
      if (set_f) begin
        flags[vabe_pkg::FLAG_Z] = (fval == 0);
        flags[vabe_pkg::FLAG_N] = fval[DW-1];
      end
      r.zero_flag = flags[vabe_pkg::FLAG_Z];
      r.negative_flag = flags[vabe_pkg::FLAG_N];
      pending.push_back(r);
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t want;
      logic      bad;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with none expected: %s", fmt(got));
        return;
      end
      want = pending.pop_front();
      bad = (got.result_a !== want.result_a) || (got.write_a !== want.write_a) ||
            (got.result_b !== want.result_b) || (got.write_b !== want.write_b) ||
            (got.branch_taken !== want.branch_taken) ||
            (got.branch_target !== want.branch_target) ||
            (got.divide_by_zero !== want.divide_by_zero) || (got.halt !== want.halt) ||
            (got.zero_flag !== want.zero_flag) ||
            (got.negative_flag !== want.negative_flag);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  vabe_in_if  in_if ();
  vabe_out_if out_if ();

  vm_alu_branch_execute_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  exec_scoreboard sb = new;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned beats_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.pending.size());
    $display("Regression FAIL");
    $finish;
  end

  // Result side: collect beats, pace ready, honor a long hold-off when requested.
  initial begin : result_sink
    exec_res_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.result_a       = out_if.result_a;
        got.write_a        = out_if.write_a;
        got.result_b       = out_if.result_b;
        got.write_b        = out_if.write_b;
        got.branch_taken   = out_if.branch_taken;
        got.branch_target  = out_if.branch_target;
        got.divide_by_zero = out_if.divide_by_zero;
        got.halt           = out_if.halt;
        got.zero_flag      = out_if.zero_flag;
        got.negative_flag  = out_if.negative_flag;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one instruction beat and wait for it to be taken; valid stays high on return.
  task automatic send_item(input vabe_pkg::op_e op, input word_t a, input word_t b,
                           input word_t acc);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.operand_a   <= a;
    in_if.operand_b   <= b;
    in_if.accumulator <= acc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(op, a, b, acc);
    beats_sent++;
  endtask

  function automatic word_t rand_val();
    case ($urandom_range(9))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return {1'b1, {(DW-1){1'b0}}};
      4: return {1'b0, {(DW-1){1'b1}}};
      5: return word_t'($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    vabe_pkg::op_e op;
    word_t         a, b, acc;
    int unsigned   pick;
    a = rand_val();
    b = rand_val();
    acc = rand_val();
    if ($urandom_range(99) < 25) begin
      // flag producer followed by a conditional jump on those flags
      case ($urandom_range(5))
        0: op = vabe_pkg::OP_CMP;
        1: op = vabe_pkg::OP_SUB;
        2: op = vabe_pkg::OP_ADD;
        3: op = vabe_pkg::OP_AND;
        4: op = vabe_pkg::OP_MOD;
        default: op = vabe_pkg::OP_DIV;
      endcase
      if ($urandom_range(2) == 0) b = a;
      send_item(op, a, b, acc);
      op = vabe_pkg::op_e'($urandom_range(vabe_pkg::OP_JNN, vabe_pkg::OP_JZ));
      send_item(op, rand_val(), rand_val(), rand_val());
      return;
    end
    op = vabe_pkg::op_e'($urandom_range(vabe_pkg::OP_STOP, vabe_pkg::OP_ADD));
    pick = $urandom_range(99);
    case (op)
      vabe_pkg::OP_DIV, vabe_pkg::OP_MOD: begin
        if (pick < 10) b = '0;
        else if (pick < 20) begin
          b = '1;
          if (pick < 15) a = {1'b1, {(DW-1){1'b0}}};
        end
      end
      vabe_pkg::OP_SHL, vabe_pkg::OP_SHR: begin
        if (pick < 70) b = $urandom_range(DW-1);
        else if (pick < 85) b = $urandom_range(DW+8, DW);
      end
      vabe_pkg::OP_JE, vabe_pkg::OP_JG, vabe_pkg::OP_JL: begin
        if (pick < 40) acc = a;
        else if (pick < 55) acc = a + 1;
        else if (pick < 70) acc = a - 1;
      end
      default: ;
    endcase
    send_item(op, a, b, acc);
  endtask

  localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= '0;
    in_if.operand_a   <= '0;
    in_if.operand_b   <= '0;
    in_if.accumulator <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wrap, division corners, zero divisor, flag and compare jumps, shifts
    send_item(vabe_pkg::OP_JP,   32'sd5, 0, 0);
    send_item(vabe_pkg::OP_ADD,  MAXV, 32'sd1, 0);
    send_item(vabe_pkg::OP_JN,   32'sd7, 0, 0);
    send_item(vabe_pkg::OP_SUB,  MINV, 32'sd1, 0);
    send_item(vabe_pkg::OP_MUL,  MAXV, MAXV, 0);
    send_item(vabe_pkg::OP_DIV,  MINV, -32'sd1, 0);
    send_item(vabe_pkg::OP_MOD,  MINV, -32'sd1, 0);
    send_item(vabe_pkg::OP_JZ,   32'sd2, 0, 0);
    send_item(vabe_pkg::OP_DIV,  32'sd9, 0, 0);
    send_item(vabe_pkg::OP_MOD,  -32'sd7, 32'sd2, 0);
    send_item(vabe_pkg::OP_MOD,  32'sd3, 0, 0);
    send_item(vabe_pkg::OP_DIV,  -32'sd7, 32'sd2, 0);
    send_item(vabe_pkg::OP_CMP,  32'sd4, 32'sd4, 0);
    send_item(vabe_pkg::OP_JNP,  MINV, 0, 0);
    send_item(vabe_pkg::OP_MOV,  0, MINV, 0);
    send_item(vabe_pkg::OP_SWAP, MAXV, MINV, 0);
    send_item(vabe_pkg::OP_JMP,  0, 0, 0);
    send_item(vabe_pkg::OP_JE,   MINV, MAXV, MINV);
    send_item(vabe_pkg::OP_JG,   MAXV, 32'sd1, MINV);
    send_item(vabe_pkg::OP_JL,   MINV, 32'sd10, MAXV);
    send_item(vabe_pkg::OP_NOT,  0, 0, 0);
    send_item(vabe_pkg::OP_JNN,  32'sd3, 0, 0);
    send_item(vabe_pkg::OP_JNZ,  32'sd3, 0, 0);
    send_item(vabe_pkg::OP_SHL,  '1, 32'sd32, 0);
    send_item(vabe_pkg::OP_SHR,  MINV, -32'sd1, 0);
    send_item(vabe_pkg::OP_SHR,  MINV, 32'sd31, 0);
    send_item(vabe_pkg::OP_STOP, 0, 0, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_left = 300; end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end
    in_if.valid <= 1'b0;
    stall_pct = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d instruction beats (all opcodes, flag-jump sequences, four pacing phases",
             beats_sent);
    $display("and one long output hold-off); %0d result beats checked, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
